>>> hw/rtl/mcr_pkg.sv
// mcr_pkg: shared types and constants of the midpoint circle rasterizer
// used by every file under hw/rtl; depends on nothing
package mcr_pkg;

  localparam int CoordW = 16;
  localparam int ColorW = 16;
  localparam int RadW   = 8;
  localparam int StepW  = 9;
  localparam int DecW   = 12;
  localparam int CntW   = 3;

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic signed [DecW-1:0] DEC_BASE     = 12'sd3;
  localparam logic signed [DecW-1:0] DEC_INC_IN   = 12'sd6;
  localparam logic signed [DecW-1:0] DEC_INC_DIAG = 12'sd10;

  localparam logic [CntW-1:0] LAST_DOT = 3'd7;

  typedef struct packed {
    logic              kind;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [RadW-1:0]   radius;
    logic              filled;
    logic [ColorW-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] dot_x;
    logic [CoordW-1:0] dot_y;
    logic [ColorW-1:0] dot_color;
    logic              last_of_run;
    logic              circle_done;
  } out_item_t;

  // one advance worth of dots, handed from the walker to the emitter
  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [ColorW-1:0] color;
    logic [StepW-1:0]  a;
    logic [StepW-1:0]  p;
    logic              done;
  } run_t;

endpackage

>>> hw/rtl/mcr_walker.sv
// mcr_walker: circle state registers and the midpoint step
// depends on mcr_pkg; feeds runs to mcr_dot_emitter
module mcr_walker import mcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     load,
  output run_t     run
);

  logic                     active_r, active_nxt;
  logic [CoordW-1:0]        cx_r, cx_nxt;
  logic [CoordW-1:0]        cy_r, cy_nxt;
  logic [ColorW-1:0]        color_r, color_nxt;
  logic                     filled_r, filled_nxt;
  logic [StepW-1:0]         a_r, a_nxt;
  logic signed [StepW-1:0]  b_r, b_nxt;
  logic [StepW-1:0]         fy_r, fy_nxt;
  logic signed [DecW-1:0]   d_r, d_nxt;

  logic [StepW-1:0]         a1;
  logic signed [DecW-1:0]   a1_s, b_s, fy1_s, a_fin_s, b_fin_s;
  logic [StepW-1:0]         fy1;
  logic                     do_step;
  logic [StepW-1:0]         a_st;
  logic signed [StepW-1:0]  b_st;
  logic signed [DecW-1:0]   d_st;

  always_comb begin
    a1    = a_r + 9'd1;
    a1_s  = signed'({3'b000, a1});
    b_s   = DecW'(b_r);
    fy1   = fy_r + 9'd1;
    fy1_s = signed'({3'b000, fy1});
    // midpoint step
    a_st = a1;
    if (d_r < 0) begin
      d_st = d_r + (a1_s <<< 2) + DEC_INC_IN;
      b_st = b_r;
    end else begin
      d_st = d_r + DEC_INC_DIAG + ((a1_s - b_s) <<< 2);
      b_st = b_r - 9'sd1;
    end

    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    filled_nxt = filled_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    fy_nxt     = fy_r;
    d_nxt      = d_r;
    do_step    = 1'b0;
    load       = 1'b0;

    if (accept && item.kind == KIND_START) begin
      active_nxt = 1'b1;
      cx_nxt     = item.center_x;
      cy_nxt     = item.center_y;
      color_nxt  = item.color;
      filled_nxt = item.filled;
      a_nxt      = '0;
      b_nxt      = signed'({1'b0, item.radius});
      fy_nxt     = '0;
      d_nxt      = DEC_BASE - signed'({3'b000, item.radius, 1'b0});
    end else if (accept && active_r) begin
      load = 1'b1;
      if (!filled_r) begin
        do_step = 1'b1;
      end else if (fy1_s > b_s) begin
        do_step = 1'b1;
        fy_nxt  = a_st;
      end else begin
        fy_nxt = fy1;
      end
      if (do_step) begin
        a_nxt = a_st;
        b_nxt = b_st;
        d_nxt = d_st;
      end
    end

    a_fin_s = signed'({3'b000, a_nxt});
    b_fin_s = DecW'(b_nxt);
    if (load && a_fin_s > b_fin_s) begin
      active_nxt = 1'b0;
    end

    run.cx    = cx_r;
    run.cy    = cy_r;
    run.color = color_r;
    run.a     = a_r;
    run.p     = filled_r ? fy_r : b_r;
    run.done  = a_fin_s > b_fin_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
      filled_r <= 1'b0;
      a_r      <= '0;
      b_r      <= '0;
      fy_r     <= '0;
      d_r      <= '0;
    end else begin
      active_r <= active_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      color_r  <= color_nxt;
      filled_r <= filled_nxt;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      fy_r     <= fy_nxt;
      d_r      <= d_nxt;
    end
  end

endmodule

>>> hw/rtl/mcr_dot_emitter.sv
// mcr_dot_emitter: holds one run and sends its eight symmetric dots
// depends on mcr_pkg; loaded by mcr_walker
module mcr_dot_emitter import mcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  run_t      run,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  run_t            run_r;
  logic            valid_r;
  logic [CntW-1:0] cnt_r;
  logic            beat, last;
  logic            swap, neg_x, neg_y;
  logic [CoordW-1:0] dx, dy;

  assign beat      = valid_r && out_ready;
  assign last      = cnt_r == LAST_DOT;
  assign free      = !valid_r || (beat && last);
  assign out_valid = valid_r;

  always_comb begin
    unique case (cnt_r)
      3'd0: begin swap = 1'b0; neg_x = 1'b0; neg_y = 1'b1; end
      3'd1: begin swap = 1'b1; neg_x = 1'b0; neg_y = 1'b1; end
      3'd2: begin swap = 1'b1; neg_x = 1'b0; neg_y = 1'b0; end
      3'd3: begin swap = 1'b0; neg_x = 1'b0; neg_y = 1'b0; end
      3'd4: begin swap = 1'b0; neg_x = 1'b1; neg_y = 1'b0; end
      3'd5: begin swap = 1'b1; neg_x = 1'b1; neg_y = 1'b0; end
      3'd6: begin swap = 1'b0; neg_x = 1'b1; neg_y = 1'b1; end
      default: begin swap = 1'b1; neg_x = 1'b1; neg_y = 1'b1; end
    endcase
    dx = swap ? CoordW'(run_r.p) : CoordW'(run_r.a);
    dy = swap ? CoordW'(run_r.a) : CoordW'(run_r.p);
    out_data.dot_x       = neg_x ? run_r.cx - dx : run_r.cx + dx;
    out_data.dot_y       = neg_y ? run_r.cy - dy : run_r.cy + dy;
    out_data.dot_color   = run_r.color;
    out_data.last_of_run = last;
    out_data.circle_done = last && run_r.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      cnt_r   <= '0;
    end else if (beat && last) begin
      valid_r <= 1'b0;
    end else if (beat) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run;
    end
  end

endmodule

>>> hw/rtl/midpoint_circle_rasterizer_core.sv
// midpoint circle rasterizer top: walker feeding a dot emitter
// latency: first dot of an advance is valid the cycle after the beat is taken
// throughput: one dot per cycle unless out_ready stalls, eight dots per advance;
// the next beat is taken in the cycle the eighth dot leaves
// reset: synchronous active-low rst_n clears the circle state and the emitter
// depends on mcr_pkg, mcr_walker, mcr_dot_emitter
module midpoint_circle_rasterizer_core import mcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic load;
  run_t run;

  mcr_walker u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_valid && in_ready),
    .item   (in_data),
    .load   (load),
    .run    (run)
  );

  mcr_dot_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .run       (run),
    .free      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/mcr_checker.sv
// mcr_checker: port-level checks on the circle rasterizer top
// depends on mcr_pkg; bound to midpoint_circle_rasterizer_core
module mcr_checker import mcr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled dot changed");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.circle_done |-> out_data.last_of_run)
    else $error("circle_done without last_of_run");

  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("run broke before its eighth dot");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("beat taken mid run");

endmodule

bind midpoint_circle_rasterizer_core mcr_checker u_mcr_checker (.*);
